// File: rtl/lcvd_pkg.sv
// shared constants and types for the lane change variance detector
package lcvd_pkg;

  // default window depth
  localparam int WINDOW_DEFAULT = 40;

  // field widths
  localparam int POS_W      = 16;
  localparam int VAR_W      = 32;
  localparam int REFR_W     = 11;
  localparam int RUN_W      = 16;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_VAR_THRESHOLD = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_REFRACTORY    = 1'd1;

  // configuration reset values
  localparam logic [VAR_W-1:0]  THRESHOLD_RESET  = 32'd268435;
  localparam logic [REFR_W-1:0] REFRACTORY_RESET = 11'd100;

  // saturation limits
  localparam logic [REFR_W-1:0] GAP_MAX = '1;
  localparam logic [RUN_W-1:0]  RUN_MAX = '1;

  // per-transaction flags carried down the pipeline
  typedef struct packed {
    logic full;   // more than WINDOW samples seen
    logic past4;  // fifth sample or later
  } lcvd_flags_t;

endpackage

// File: rtl/lane_change_variance_detector.sv
// top level of the lane change variance detector
//
// One transaction per clock when the result side keeps up: each lateral
// position sample goes through a twelve-stage pipeline whose last stage,
// stage 11, is the result register. Running sums over two cell
// chains (samples, and variances) keep each step constant work; the
// variance is the population variance of the last WINDOW samples, with the
// division by WINDOW squared done as a split reciprocal multiply and a
// single correction step. Stages that hold no transaction take new ones
// even while a finished result waits, so in_stall rises only once every
// stage is occupied and out_stall is high. Configuration writes take
// effect at once and belong in idle periods.
module lane_change_variance_detector
  import lcvd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [POS_W-1:0]      in_lateral_position,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_lane_change,
  output logic [VAR_W-1:0]             out_window_variance,
  output logic [RUN_W-1:0]             out_run_length,
  input  logic                         cfg_we,
  input  logic [CFG_ADDR_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data
);

  // derived widths
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int CNTW  = $clog2(WINDOW + 2);
  localparam int PSW   = POS_W + CW;            // signed sample sum
  localparam int ASW   = POS_W - 1 + CW;        // magnitude of the sum
  localparam int SQ1W  = 2 * POS_W - 1;         // one square
  localparam int SQW   = 2 * POS_W - 2 + CW;    // sum of squares
  localparam int NUMW  = SQW + CW;              // variance numerator
  localparam int DIVD  = WINDOW * WINDOW;
  localparam int DW    = $clog2(DIVD + 1);
  localparam int MW    = NUMW - $clog2(DIVD) + 1; // reciprocal and quotient
  localparam int HLO   = NUMW / 2;
  localparam int HHI   = NUMW - HLO;
  localparam int SUMW  = HHI + MW + 1;
  localparam int VXW   = (MW + 1 > VAR_W + 1) ? MW + 1 : VAR_W + 1;
  localparam int VSW   = VAR_W + CW;
  localparam int NST   = 12;

  localparam logic [63:0]     RECIP64 = (64'd1 << NUMW) / 64'(DIVD);
  localparam logic [MW-1:0]   RECIP_C = RECIP64[MW-1:0];
  localparam logic [DW-1:0]   DIV_C   = DW'(DIVD);
  localparam logic [CW-1:0]   W_C     = CW'(WINDOW);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(WINDOW + 1);
  localparam logic [CNTW-1:0] CNT_PAST4 = CNTW'(4);
  localparam logic [VXW-1:0]  VAR_SAT = VXW'({VAR_W{1'b1}});

  // configuration registers
  logic [VAR_W-1:0]  threshold_r;
  logic [REFR_W-1:0] refractory_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RESET;
      refractory_r <= REFRACTORY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VAR_THRESHOLD: threshold_r  <= cfg_data[VAR_W-1:0];
        REG_REFRACTORY:    refractory_r <= cfg_data[REFR_W-1:0];
        default:           ;
      endcase
    end
  end

  // stage occupancy and transfer control
  logic [NST-1:0] v_r, v_nxt, ld, rdy, drain;

  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    ld[0] = in_valid && rdy[0];
    for (int k = 1; k < NST; k++) begin
      ld[k] = v_r[k-1] && rdy[k];
    end
    for (int k = 0; k < NST - 1; k++) begin
      drain[k] = ld[k+1];
    end
    drain[NST-1] = v_r[NST-1] && !out_stall;
    for (int k = 0; k < NST; k++) begin
      v_nxt[k] = ld[k] || (v_r[k] && !drain[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  // sample counter, saturating one past the window
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  lcvd_flags_t     flags_in;

  always_comb begin
    cnt_nxt        = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + 1'b1;
    flags_in.full  = (cnt_nxt == CNT_MAX);
    flags_in.past4 = (cnt_nxt > CNT_PAST4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ld[0]) begin
      cnt_r <= cnt_nxt;
    end
  end

  // flags travel with each transaction
  lcvd_flags_t flags_r [NST-1];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      flags_r[0] <= flags_in;
    end
    for (int k = 1; k < NST - 1; k++) begin
      if (ld[k]) begin
        flags_r[k] <= flags_r[k-1];
      end
    end
  end

  // sample window chain
  logic [POS_W-1:0] pos_tail;

  lcvd_chain #(
    .DEPTH (WINDOW),
    .DW    (POS_W)
  ) u_pos_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (ld[0]),
    .din      (in_lateral_position),
    .tail     (pos_tail)
  );

  // stage 0: new sample and the one leaving the window
  logic signed [POS_W-1:0] x0_r, old0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x0_r   <= in_lateral_position;
      old0_r <= $signed(pos_tail);
    end
  end

  // stage 1: squares and the running sample sum
  logic signed [2*POS_W-1:0] xsq_w, osq_w;
  logic [SQ1W-1:0]           xsq1_r, osq1_r;
  logic signed [PSW-1:0]     psum_r;

  assign xsq_w = (2*POS_W)'(x0_r) * (2*POS_W)'(x0_r);
  assign osq_w = (2*POS_W)'(old0_r) * (2*POS_W)'(old0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
    end else if (ld[1]) begin
      psum_r <= psum_r + PSW'(x0_r) - PSW'(old0_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      xsq1_r <= xsq_w[SQ1W-1:0];
      osq1_r <= osq_w[SQ1W-1:0];
    end
  end

  // stage 2: running sum of squares and magnitude of the sample sum
  logic [SQW-1:0]        sqsum_r;
  logic [ASW-1:0]        asum2_r;
  logic signed [PSW-1:0] psum_neg;

  assign psum_neg = -psum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqsum_r <= '0;
    end else if (ld[2]) begin
      sqsum_r <= sqsum_r + SQW'(xsq1_r) - SQW'(osq1_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      asum2_r <= psum_r[PSW-1] ? psum_neg[ASW-1:0] : psum_r[ASW-1:0];
    end
  end

  // stage 3: square of the sum and window-scaled sum of squares
  logic [NUMW-1:0] sq3_r, scaled3_r;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      sq3_r     <= NUMW'(asum2_r) * NUMW'(asum2_r);
      scaled3_r <= NUMW'(sqsum_r) * NUMW'(W_C);
    end
  end

  // stage 4: numerator, clamped at zero
  logic [NUMW-1:0] num4_r;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      num4_r <= (scaled3_r > sq3_r) ? scaled3_r - sq3_r : '0;
    end
  end

  // stage 5: low partial product with the reciprocal
  logic [HLO+MW-1:0] plo5_r, plo6_r;
  logic [NUMW-1:0]   num5_r, num6_r, num7_r, num8_r;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      plo5_r <= (HLO+MW)'(num4_r[HLO-1:0]) * (HLO+MW)'(RECIP_C);
      num5_r <= num4_r;
    end
  end

  // stage 6: high partial product
  logic [HHI+MW-1:0] phi6_r;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      phi6_r <= (HHI+MW)'(num5_r[NUMW-1:HLO]) * (HHI+MW)'(RECIP_C);
      plo6_r <= plo5_r;
      num6_r <= num5_r;
    end
  end

  // stage 7: combine partial products into the quotient estimate
  logic [SUMW-1:0] psum7_w;
  logic [MW-1:0]   q7_r, q8_r;

  assign psum7_w = SUMW'(phi6_r) + SUMW'(plo6_r[HLO+MW-1:HLO]);

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      q7_r   <= psum7_w[HHI +: MW];
      num7_r <= num6_r;
    end
  end

  // stage 8: estimate times divisor
  logic [NUMW-1:0] qd8_r;

  always_ff @(posedge clk) begin
    if (ld[8]) begin
      qd8_r  <= NUMW'(q7_r) * NUMW'(DIV_C);
      q8_r   <= q7_r;
      num8_r <= num7_r;
    end
  end

  // stage 9: one correction step and saturation
  logic [NUMW-1:0]  rem9_w;
  logic [VXW-1:0]   qfix9_w;
  logic [VAR_W-1:0] var9_r;

  always_comb begin
    rem9_w  = num8_r - qd8_r;
    qfix9_w = VXW'(q8_r) + VXW'(rem9_w >= NUMW'(DIVD));
  end

  always_ff @(posedge clk) begin
    if (ld[9]) begin
      var9_r <= (qfix9_w > VAR_SAT) ? {VAR_W{1'b1}} : qfix9_w[VAR_W-1:0];
    end
  end

  // stage 10: variance window chain and running variance sum
  logic [VAR_W-1:0] var_tail;
  logic [VAR_W-1:0] var10_r;
  logic [VSW-1:0]   vsum_r;

  lcvd_chain #(
    .DEPTH (WINDOW),
    .DW    (VAR_W)
  ) u_var_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (ld[10]),
    .din      (var9_r),
    .tail     (var_tail)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vsum_r <= '0;
    end else if (ld[10]) begin
      vsum_r <= vsum_r - VSW'(var_tail) + VSW'(var9_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[10]) begin
      var10_r <= var9_r;
    end
  end

  // stage 11: decision and result register
  lcvd_decide #(
    .WINDOW (WINDOW)
  ) u_decide (
    .clk             (clk),
    .rst_n           (rst_n),
    .en              (ld[11]),
    .variance        (var10_r),
    .var_sum         (vsum_r),
    .flags           (flags_r[NST-2]),
    .threshold       (threshold_r),
    .refractory      (refractory_r),
    .lane_change     (out_lane_change),
    .window_variance (out_window_variance),
    .run_length      (out_run_length)
  );

`ifndef SYNTHESIS
  // an empty result stage lets the whole pipeline take a transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty result stage");

  // a run length is only reported on a sample that is not flagged
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lane_change) |-> (out_run_length == '0))
    else $error("run length reported on a flagged sample");

  // sample counter saturates one past the window
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("sample counter past its limit");

  // the counter moves only when a transaction is accepted
  assert property (@(posedge clk) disable iff (!rst_n)
    (!in_valid || in_stall) |=> $stable(cnt_r))
    else $error("sample counter moved without a transaction");
`endif

endmodule

// File: rtl/lcvd_cell.sv
// one cell of a shift chain, holds one window entry
module lcvd_cell #(
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic [DW-1:0] d,
  output logic [DW-1:0] q
);

  logic [DW-1:0] val_r;

  // entry takes its neighbor's value on every shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (shift_en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

// File: rtl/lcvd_chain.sv
// row of cells forming a window delay line, tail is the entry leaving the window
module lcvd_chain #(
  parameter int DEPTH = 40,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift_en,
  input  logic [DW-1:0] din,
  output logic [DW-1:0] tail
);

  logic [DW-1:0] link [DEPTH+1];

  assign link[0] = din;

  // each cell hands its entry to the next one
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    lcvd_cell #(
      .DW (DW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .d        (link[i]),
      .q        (link[i+1])
    );
  end

  assign tail = link[DEPTH];

endmodule

// File: rtl/lcvd_decide.sv
// detection decision, gap and run tracking, and the result register
module lcvd_decide
  import lcvd_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  en,
  input  logic [VAR_W-1:0]                      variance,
  input  logic [VAR_W+$clog2(WINDOW+1)-1:0]     var_sum,
  input  lcvd_flags_t                           flags,
  input  logic [VAR_W-1:0]                      threshold,
  input  logic [REFR_W-1:0]                     refractory,
  output logic                                  lane_change,
  output logic [VAR_W-1:0]                      window_variance,
  output logic [RUN_W-1:0]                      run_length
);

  localparam int CW  = $clog2(WINDOW + 1);
  localparam int VSW = VAR_W + CW;
  localparam logic [CW-1:0] W_C = CW'(WINDOW);

  logic [REFR_W-1:0] gap_r, gap_nxt, gap_base;
  logic              seen_r, seen_nxt;
  logic              prev_r, prev_nxt;
  logic              in_run_r, in_run_nxt;
  logic [RUN_W-1:0]  run_cnt_r, run_cnt_nxt;
  logic [RUN_W-1:0]  run_out;
  logic [VSW-1:0]    var_times_w;
  logic              det;
  logic              run_end;
  logic              lane_change_r;
  logic [VAR_W-1:0]  variance_r;
  logic [RUN_W-1:0]  run_length_r;

  // variance above window mean, above threshold, window full, gap allows it
  always_comb begin
    var_times_w = VSW'(variance) * VSW'(W_C);
    det = (var_times_w > var_sum) && (variance > threshold) && flags.full &&
          ((gap_r > refractory) || !seen_r);
  end

  // gap counter and end-of-change tracking from the fifth sample on
  always_comb begin
    run_end  = flags.past4 && !det && prev_r;
    gap_base = run_end ? '0 : gap_r;
    gap_nxt  = gap_r;
    prev_nxt = prev_r;
    seen_nxt = seen_r | run_end;
    if (flags.past4) begin
      prev_nxt = det;
      gap_nxt  = (gap_base == GAP_MAX) ? gap_base : gap_base + 1'b1;
    end
  end

  // run length: report at run end, clear on the second quiet sample
  always_comb begin
    run_cnt_nxt = run_cnt_r;
    in_run_nxt  = in_run_r;
    run_out     = '0;
    if (det) begin
      run_cnt_nxt = (run_cnt_r == RUN_MAX) ? run_cnt_r : run_cnt_r + 1'b1;
      in_run_nxt  = 1'b1;
    end else if (in_run_r) begin
      in_run_nxt = 1'b0;
      run_out    = run_cnt_r;
    end else begin
      run_cnt_nxt = '0;
    end
  end

  // tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r     <= '0;
      seen_r    <= 1'b0;
      prev_r    <= 1'b0;
      in_run_r  <= 1'b0;
      run_cnt_r <= '0;
    end else if (en) begin
      gap_r     <= gap_nxt;
      seen_r    <= seen_nxt;
      prev_r    <= prev_nxt;
      in_run_r  <= in_run_nxt;
      run_cnt_r <= run_cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      lane_change_r <= det;
      variance_r    <= variance;
      run_length_r  <= run_out;
    end
  end

  assign lane_change     = lane_change_r;
  assign window_variance = variance_r;
  assign run_length      = run_length_r;

endmodule
